/* sv/deadline_job_sequencer_macros.svh */
// assertion macros for the deadline job sequencer checker
// clocked on aclk and quiet while aresetn is low
`ifndef DEADLINE_JOB_SEQUENCER_MACROS_SVH
`define DEADLINE_JOB_SEQUENCER_MACROS_SVH

// same-cycle implication
`define DJS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("deadline_job_sequencer: assertion failed");

// next-cycle implication
`define DJS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("deadline_job_sequencer: assertion failed");

`endif

/* sv/djs_pkg.sv */
package djs_pkg;

    localparam int DL_W        = 10;
    localparam int PF_W        = 20;
    localparam int DONE_W      = 7;
    localparam int TOT_W       = 26;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 40;
    localparam int OUT_PAD_W   = OUT_DATA_W - DONE_W - TOT_W - 1;
    localparam int SLOT_WORD   = 32;
    localparam int SLOT_POS_W  = 5;
    localparam int DONE_MAX    = 127;

    typedef struct packed {
        logic [DL_W-1:0] deadline;
        logic [PF_W-1:0] profit;
    } djs_job_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_POP,
        ST_SEARCH,
        ST_POST
    } djs_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic pop;
        logic start;
        logic post;
    } djs_cmd_t;

    typedef struct packed {
        logic empty;
        logic overflow;
    } djs_chain_stat_t;

    typedef struct packed {
        logic busy;
        logic finishing;
        logic out_free;
    } djs_alloc_stat_t;

    // higher profit first, larger deadline first on a tie
    function automatic logic goes_before(djs_job_t a, djs_job_t b);
        logic r;
        if (a.profit != b.profit) begin
            r = a.profit > b.profit;
        end else begin
            r = a.deadline > b.deadline;
        end
        return r;
    endfunction

endpackage

/* sv/djs_ctrl.sv */
module djs_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    input  logic                     s_tlast,
    output logic                     s_tready,
    input  djs_pkg::djs_chain_stat_t chain_stat,
    input  djs_pkg::djs_alloc_stat_t alloc_stat,
    output djs_pkg::djs_cmd_t        cmd
);

    djs_pkg::djs_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= djs_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            djs_pkg::ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (s_tlast) begin
                        state_next = djs_pkg::ST_POP;
                    end
                end
            end
            djs_pkg::ST_POP: begin
                if (chain_stat.empty) begin
                    state_next = djs_pkg::ST_POST;
                end else begin
                    // head goes to the allocator as the chain shifts up
                    cmd.start  = 1'b1;
                    cmd.pop    = 1'b1;
                    state_next = djs_pkg::ST_SEARCH;
                end
            end
            djs_pkg::ST_SEARCH: begin
                if (!alloc_stat.busy || alloc_stat.finishing) begin
                    state_next = djs_pkg::ST_POP;
                end
            end
            djs_pkg::ST_POST: begin
                if (alloc_stat.out_free) begin
                    cmd.post   = 1'b1;
                    state_next = djs_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = djs_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

/* sv/djs_chain.sv */
module djs_chain #(
    parameter int MAX_JOBS = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  djs_pkg::djs_cmd_t        cmd,
    input  djs_pkg::djs_job_t        in_job,
    output djs_pkg::djs_job_t        head_job,
    output djs_pkg::djs_chain_stat_t stat
);

    localparam int CNT_W = $clog2(MAX_JOBS + 1);

    djs_pkg::djs_job_t cell_reg  [MAX_JOBS];
    djs_pkg::djs_job_t cell_next [MAX_JOBS];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [MAX_JOBS-1:0] ins;
    logic              full;
    logic              store;

    assign full  = count_reg == CNT_W'(MAX_JOBS);
    assign store = cmd.load && !full;

    // cells hold a sorted run; ins marks where the new job and everything below it sit
    always_comb begin
        for (int i = 0; i < MAX_JOBS; i++) begin
            ins[i] = (CNT_W'(i) >= count_reg) || djs_pkg::goes_before(in_job, cell_reg[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_JOBS; i++) begin
            cell_next[i] = cell_reg[i];
            if (store && ins[i]) begin
                cell_next[i] = in_job;
            end
        end
        for (int i = 1; i < MAX_JOBS; i++) begin
            if (store && ins[i-1]) begin
                cell_next[i] = cell_reg[i-1];
            end
        end
        if (cmd.pop) begin
            for (int i = 0; i < MAX_JOBS - 1; i++) begin
                cell_next[i] = cell_reg[i+1];
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.post) begin
            count_next = '0;
            ovf_next   = 1'b0;
        end else if (cmd.load) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end else if (cmd.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_JOBS; i++) begin
            cell_reg[i] <= cell_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign head_job      = cell_reg[0];
    assign stat.empty    = count_reg == '0;
    assign stat.overflow = ovf_reg;

endmodule

/* sv/djs_alloc.sv */
module djs_alloc #(
    parameter int MAX_JOBS = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  djs_pkg::djs_cmd_t                    cmd,
    input  djs_pkg::djs_job_t                    head_job,
    input  logic                                 overflow,
    input  logic                                 m_tready,
    output logic                                 out_valid,
    output logic [djs_pkg::DONE_W-1:0]           out_done,
    output logic [djs_pkg::TOT_W-1:0]            out_total,
    output logic                                 out_ovf,
    output djs_pkg::djs_alloc_stat_t             stat
);

    localparam int CNT_W  = $clog2(MAX_JOBS + 1);
    localparam int NWORDS = (MAX_JOBS + djs_pkg::SLOT_WORD - 1) / djs_pkg::SLOT_WORD;
    localparam int WIDX_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int HI_W   = djs_pkg::DL_W + 1;
    localparam int SW     = djs_pkg::SLOT_WORD;
    localparam int PW     = djs_pkg::SLOT_POS_W;
    localparam int TW     = djs_pkg::TOT_W;

    logic [SW-1:0]             slot_reg [NWORDS];
    logic [SW-1:0]             slot_next [NWORDS];
    logic                      active_reg, active_next;
    logic [WIDX_W-1:0]         wptr_reg, wptr_next;
    logic [SW-1:0]             mask_reg, mask_next;
    logic [djs_pkg::PF_W-1:0]  profit_reg, profit_next;
    logic [CNT_W-1:0]          done_reg, done_next;
    logic [TW-1:0]             total_reg, total_next;
    logic                      out_valid_reg, out_valid_next;
    logic [djs_pkg::DONE_W-1:0] out_done_reg;
    logic [TW-1:0]             out_total_reg;
    logic                      out_ovf_reg;

    logic [HI_W-1:0]           dm1, lim, hi;
    logic [SW-1:0]             word, avail;
    logic                      found;
    logic [PW-1:0]             sel;
    logic [TW:0]               sum;
    logic [djs_pkg::DONE_W-1:0] done_sat;

    // last usable slot of the incoming job
    assign dm1 = {1'b0, head_job.deadline} - HI_W'(1);
    assign lim = HI_W'(MAX_JOBS - 1);
    assign hi  = (dm1 > lim) ? lim : dm1;

    // one slot word per cycle, highest free bit under the mask
    assign word  = slot_reg[wptr_reg];
    assign avail = ~word & mask_reg;
    assign found = |avail;

    always_comb begin
        sel = '0;
        for (int b = 0; b < SW; b++) begin
            if (avail[b]) begin
                sel = PW'(b);
            end
        end
    end

    assign sum = {1'b0, total_reg} + (TW+1)'(profit_reg);
    assign done_sat = (32'(done_reg) > 32'(djs_pkg::DONE_MAX))
                      ? djs_pkg::DONE_W'(djs_pkg::DONE_MAX) : djs_pkg::DONE_W'(done_reg);

    always_comb begin
        slot_next   = slot_reg;
        active_next = active_reg;
        wptr_next   = wptr_reg;
        mask_next   = mask_reg;
        profit_next = profit_reg;
        done_next   = done_reg;
        total_next  = total_reg;
        if (cmd.post) begin
            for (int w = 0; w < NWORDS; w++) begin
                slot_next[w] = '0;
            end
            active_next = 1'b0;
            done_next   = '0;
            total_next  = '0;
        end else if (cmd.start) begin
            // zero deadline never gets a slot
            active_next = head_job.deadline != '0;
            wptr_next   = WIDX_W'(hi >> PW);
            mask_next   = {SW{1'b1}} >> (PW'(SW - 1) - hi[PW-1:0]);
            profit_next = head_job.profit;
        end else if (active_reg) begin
            if (found) begin
                slot_next[wptr_reg][sel] = 1'b1;
                active_next = 1'b0;
                done_next   = done_reg + CNT_W'(1);
                total_next  = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
            end else if (wptr_reg == '0) begin
                active_next = 1'b0;
            end else begin
                wptr_next = wptr_reg - WIDX_W'(1);
                mask_next = {SW{1'b1}};
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.post) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < NWORDS; w++) begin
                slot_reg[w] <= '0;
            end
            active_reg    <= 1'b0;
            done_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            slot_reg      <= slot_next;
            active_reg    <= active_next;
            done_reg      <= done_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wptr_reg   <= wptr_next;
        mask_reg   <= mask_next;
        profit_reg <= profit_next;
        if (cmd.post) begin
            out_done_reg  <= done_sat;
            out_total_reg <= total_reg;
            out_ovf_reg   <= overflow;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_done       = out_done_reg;
    assign out_total      = out_total_reg;
    assign out_ovf        = out_ovf_reg;
    assign stat.busy      = active_reg;
    assign stat.finishing = active_reg && (found || wptr_reg == '0);
    assign stat.out_free  = !out_valid_reg || m_tready;

endmodule

/* sv/deadline_job_sequencer.sv */
// channel   dir  tdata                                   tlast
// s_        in   deadline[9:0] profit[29:10]             last job of batch
// m_        out  jobs_done[6:0] total_profit[32:7]       -
//                overflow[33]
//
// jobs load one per cycle into a sorted insertion chain, highest profit at the head.
// after the last job each stored job is popped to the allocator, which scans the slot map
// one 32-slot word at a time, downward from the word that holds its last usable slot,
// and skips the scan for a zero deadline; then the controller finds the chain empty and posts.
// s_tready stays low through the pass; a waiting result only holds off the next post.
// aresetn is synchronous; reset empties the chain and the slot map at once.
module deadline_job_sequencer #(
    parameter int MAX_JOBS = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [djs_pkg::IN_DATA_W-1:0]      s_tdata,  // deadline, profit, zero fill
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [djs_pkg::OUT_DATA_W-1:0]     m_tdata   // jobs_done, total_profit, overflow, zero fill
);

    djs_pkg::djs_cmd_t          cmd;
    djs_pkg::djs_chain_stat_t   chain_stat;
    djs_pkg::djs_alloc_stat_t   alloc_stat;
    djs_pkg::djs_job_t          in_job;
    djs_pkg::djs_job_t          head_job;
    logic [djs_pkg::DONE_W-1:0] out_done;
    logic [djs_pkg::TOT_W-1:0]  out_total;
    logic                       out_ovf;

    assign in_job.deadline = s_tdata[djs_pkg::DL_W-1:0];
    assign in_job.profit   = s_tdata[djs_pkg::DL_W +: djs_pkg::PF_W];

    djs_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tlast    (s_tlast),
        .s_tready   (s_tready),
        .chain_stat (chain_stat),
        .alloc_stat (alloc_stat),
        .cmd        (cmd)
    );

    djs_chain #(
        .MAX_JOBS (MAX_JOBS)
    ) u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_job   (in_job),
        .head_job (head_job),
        .stat     (chain_stat)
    );

    djs_alloc #(
        .MAX_JOBS (MAX_JOBS)
    ) u_alloc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .head_job  (head_job),
        .overflow  (chain_stat.overflow),
        .m_tready  (m_tready),
        .out_valid (m_tvalid),
        .out_done  (out_done),
        .out_total (out_total),
        .out_ovf   (out_ovf),
        .stat      (alloc_stat)
    );

    assign m_tdata = {{djs_pkg::OUT_PAD_W{1'b0}}, out_ovf, out_total, out_done};

endmodule

/* sv/djs_checker.sv */
`include "deadline_job_sequencer_macros.svh"

module djs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [djs_pkg::OUT_DATA_W-1:0] m_tdata
);

    // a stalled result stays up
    `DJS_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid)

    // closing transfer starts the allocation pass, so no input is taken right after
    `DJS_ASSERT_NEXT(a_busy_after_last, s_tvalid && s_tready && s_tlast, !s_tready)

    // no placed job means no profit
    `DJS_ASSERT_NOW(a_zero_done_zero_profit, m_tvalid && (m_tdata[6:0] == 7'd0),
                    m_tdata[32:7] == 26'd0)

    // a new result only comes out of the allocation pass
    `DJS_ASSERT_NOW(a_result_from_pass, $rose(m_tvalid), $past(!s_tready))

endmodule

bind deadline_job_sequencer djs_checker u_djs_checker (.*);

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int DL_W        = djs_pkg::DL_W;
    localparam int PF_W        = djs_pkg::PF_W;
    localparam int DONE_W      = djs_pkg::DONE_W;
    localparam int TOT_W       = djs_pkg::TOT_W;
    localparam int IN_DATA_W   = djs_pkg::IN_DATA_W;
    localparam int OUT_DATA_W  = djs_pkg::OUT_DATA_W;
    localparam int JOB_SLOTS   = 64;
    localparam int SUM_LSB     = DONE_W;
    localparam int OVF_BIT     = DONE_W + TOT_W;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 400;

    typedef struct packed {
        logic [DL_W-1:0] deadline;
        logic [PF_W-1:0] profit;
    } job_rec_t;

    typedef struct packed {
        logic [DONE_W-1:0] jobs_done;
        logic [TOT_W-1:0]  profit_sum;
        logic              overflow;
    } batch_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    job_rec_t      batch_jobs[$];
    bit            batch_overflow;
    batch_result_t expected_results[$];
    batch_result_t head;
    int            mismatch_count;
    int            cycle_count;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            hold_request;
    int            hold_left;

    deadline_job_sequencer #(
        .MAX_JOBS(JOB_SLOTS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #4 aclk = ~aclk;

    // greedy allocation of the stored batch
    function automatic batch_result_t schedule_batch();
        job_rec_t            ordered[$];
        bit [JOB_SLOTS-1:0]  taken;
        batch_result_t       res;
        int                  pos;
        int                  top;
        int unsigned         done;
        longint unsigned     total;
        taken = '0;
        done = 0;
        total = 0;
        foreach (batch_jobs[i]) begin
            pos = 0;
            while (pos < ordered.size() &&
                   (ordered[pos].profit > batch_jobs[i].profit ||
                    (ordered[pos].profit == batch_jobs[i].profit &&
                     ordered[pos].deadline >= batch_jobs[i].deadline)))
                pos++;
            ordered.insert(pos, batch_jobs[i]);
        end
        foreach (ordered[i]) begin
            if (ordered[i].deadline != 0) begin
                top = int'(ordered[i].deadline) - 1;
                if (top > JOB_SLOTS - 1) begin
                    top = JOB_SLOTS - 1;
                end
                for (int s = top; s >= 0; s--) begin
                    if (!taken[s]) begin
                        taken[s] = 1'b1;
                        done++;
                        total += ordered[i].profit;
                        break;
                    end
                end
            end
        end
        if (done > 127) done = 127;
        if (total > 64'h3FF_FFFF) total = 64'h3FF_FFFF;
        res.jobs_done  = done[DONE_W-1:0];
        res.profit_sum = total[TOT_W-1:0];
        res.overflow   = batch_overflow;
        return res;
    endfunction

    // called right after a rising edge; returns right after the edge of the transfer
    task automatic send_job(input logic [DL_W-1:0] dl, input logic [PF_W-1:0] pf,
                            input logic lst);
        job_rec_t rec;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W-DL_W-PF_W){1'b0}}, pf, dl};
        s_tlast  <= lst;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        if (batch_jobs.size() < JOB_SLOTS) begin
            rec.deadline = dl;
            rec.profit   = pf;
            batch_jobs.insert(batch_jobs.size(), rec);
        end else begin
            batch_overflow = 1'b1;
        end
        if (lst) begin
            expected_results.insert(expected_results.size(), schedule_batch());
            batch_jobs.delete();
            batch_overflow = 1'b0;
        end
    endtask

    function automatic logic [DL_W-1:0] random_deadline(input int batch_len);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 70) return DL_W'($urandom_range(1, batch_len + 1));
        if (r < 85) return DL_W'($urandom_range(1, JOB_SLOTS));
        return DL_W'($urandom);
    endfunction

    function automatic logic [PF_W-1:0] random_profit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return PF_W'($urandom_range(0, 15));
        if (r < 35) return '1;
        if (r < 40) return '0;
        return PF_W'($urandom);
    endfunction

    task automatic test_directed();
        // zero deadline alone
        send_job(10'd0, 20'd5, 1'b1);
        // field extremes, zero-deadline closing job
        send_job(10'd1, 20'hFFFFF, 1'b0);
        send_job(10'd1023, 20'hFFFFF, 1'b0);
        send_job(10'd1, 20'd0, 1'b0);
        send_job(10'd2, 20'd100, 1'b0);
        send_job(10'd0, 20'hFFFFF, 1'b1);
        // equal profits: larger deadline is served first
        send_job(10'd1, 20'd50, 1'b0);
        send_job(10'd3, 20'd50, 1'b0);
        send_job(10'd2, 20'd50, 1'b0);
        send_job(10'd1, 20'd50, 1'b0);
        send_job(10'd3, 20'd50, 1'b1);
        // deadlines at and past the top of the slot range clamp to the top slot
        send_job(10'd100, 20'd7, 1'b0);
        send_job(10'd64, 20'd8, 1'b0);
        send_job(10'd65, 20'd9, 1'b0);
        send_job(10'd1023, 20'd10, 1'b1);
        // zero profits
        send_job(10'd1, 20'd0, 1'b0);
        send_job(10'd1, 20'd0, 1'b1);
        send_job(10'd1023, 20'hFFFFF, 1'b1);
    endtask

    task automatic test_overflow();
        // full batch at max profit, no overflow
        for (int k = 0; k < JOB_SLOTS; k++) begin
            send_job(10'd64, 20'hFFFFF, k == JOB_SLOTS - 1);
        end
        // the closing job itself is dropped
        for (int k = 0; k <= JOB_SLOTS; k++) begin
            send_job(random_deadline(JOB_SLOTS), random_profit(), k == JOB_SLOTS);
        end
        for (int k = 0; k < JOB_SLOTS + 3; k++) begin
            send_job(random_deadline(8), random_profit(), k == JOB_SLOTS + 2);
        end
    endtask

    task automatic test_backpressure();
        hold_request = 400;
        for (int b = 0; b < 8; b++) begin
            for (int k = 0; k < 5; k++) begin
                send_job(random_deadline(5), random_profit(), k == 4);
            end
        end
    endtask

    task automatic test_random(input int n_items);
        int sent;
        int batch_len;
        int r;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 70) batch_len = $urandom_range(1, 8);
            else if (r < 92) batch_len = $urandom_range(9, 40);
            else if (r < 97) batch_len = $urandom_range(41, JOB_SLOTS);
            else batch_len = $urandom_range(JOB_SLOTS + 1, JOB_SLOTS + 4);
            for (int k = 0; k < batch_len; k++) begin
                send_job(random_deadline(batch_len), random_profit(), k == batch_len - 1);
            end
            sent += batch_len;
        end
    endtask

    // result receiver, with an optional long hold-off
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, actual %h",
                         $time, m_tdata);
                mismatch_count++;
            end else begin
                head = expected_results.pop_front();
                if (m_tdata[SUM_LSB-1:0] !== head.jobs_done) begin
                    $display("%0t: jobs_done expected %0d actual %0d", $time,
                             head.jobs_done, m_tdata[SUM_LSB-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[OVF_BIT-1:SUM_LSB] !== head.profit_sum) begin
                    $display("%0t: total_profit expected %0d actual %0d", $time,
                             head.profit_sum, m_tdata[OVF_BIT-1:SUM_LSB]);
                    mismatch_count++;
                end
                if (m_tdata[OVF_BIT] !== head.overflow) begin
                    $display("%0t: overflow expected %0b actual %0b", $time,
                             head.overflow, m_tdata[OVF_BIT]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        send_idle_pct = 36;
        recv_idle_pct = 77;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_overflow();
        test_random(200);

        send_idle_pct = 77;
        recv_idle_pct = 36;
        test_random(200);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(200);

        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/djs_pkg.sv
sv/djs_ctrl.sv
sv/djs_chain.sv
sv/djs_alloc.sv
sv/deadline_job_sequencer.sv
sv/djs_checker.sv
verif/tb.sv
